### sv/barometric_sensor_compensation_core_defines.svh
// Assertion macros shared by the compensation core.
// Needs clock and reset in the scope of the module that uses them.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication
`define BSC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bsc_pkg.sv
// Types, register indexes and helpers for the compensation core.
// No dependencies.
package bsc_pkg;

   localparam int DIV_STAGES = 32;

   localparam logic [2:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [2:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [2:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [2:0] CSR_B1_B2   = 3'd3;
   localparam logic [2:0] CSR_MC_MD   = 3'd4;
   localparam logic [2:0] CSR_MODE    = 3'd5;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  mode;
   } calib_type;

   // travels beside the temperature divide
   typedef struct packed {
      logic        neg;
      logic        err;
      logic [23:0] up;
      logic [31:0] x1;
   } side1_type;

   // travels beside the pressure divide
   typedef struct packed {
      logic        ovf;
      logic        err;
      logic [31:0] temp;
   } side2_type;

   localparam int SIDE_W  = $bits(side1_type);
   localparam int SIDE2_W = $bits(side2_type);

   typedef struct packed {
      logic              valid;
      logic [31:0]       num;
      logic [31:0]       den;
      logic [SIDE_W-1:0] side;
   } div_req_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       quo;
      logic [SIDE_W-1:0] side;
   } div_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] temp;
      logic [31:0] pres;
      logic        err;
   } res_type;

   // signed divide by 2^k, truncating toward zero
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
      logic [31:0] bias;
      bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return 32'($signed(a + bias) >>> k);
   endfunction

   function automatic logic [31:0] half_s(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

endpackage

### sv/bsc_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bsc_pkg.
module bsc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  bsc_pkg::div_req_type req,
   output bsc_pkg::div_rsp_type rsp
);

   logic                      valid_ff [bsc_pkg::DIV_STAGES];
   logic [31:0]               rem_ff   [bsc_pkg::DIV_STAGES];
   logic [31:0]               nq_ff    [bsc_pkg::DIV_STAGES];
   logic [31:0]               den_ff   [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::SIDE_W-1:0] side_ff [bsc_pkg::DIV_STAGES];

   for (genvar i = 0; i < bsc_pkg::DIV_STAGES; i++) begin : g_stage
      logic                      v_prev;
      logic [31:0]               r_prev, nq_prev, d_prev;
      logic [bsc_pkg::SIDE_W-1:0] s_prev;
      logic [32:0]               trial, diff;
      logic [31:0]               rem_in, nq_in;

      if (i == 0) begin : g_first
         assign v_prev  = req.valid;
         assign r_prev  = '0;
         assign nq_prev = req.num;
         assign d_prev  = req.den;
         assign s_prev  = req.side;
      end else begin : g_next
         assign v_prev  = valid_ff[i-1];
         assign r_prev  = rem_ff[i-1];
         assign nq_prev = nq_ff[i-1];
         assign d_prev  = den_ff[i-1];
         assign s_prev  = side_ff[i-1];
      end

      // remainder stays below the divisor, so trial fits 33 bits
      assign trial  = {r_prev, nq_prev[31]};
      assign diff   = trial - {1'b0, d_prev};
      assign rem_in = diff[32] ? trial[31:0] : diff[31:0];
      assign nq_in  = {nq_prev[30:0], ~diff[32]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= nq_in;
            den_ff[i]  <= d_prev;
            side_ff[i] <= s_prev;
         end
      end
   end

   assign rsp.valid = valid_ff[bsc_pkg::DIV_STAGES-1];
   assign rsp.quo   = nq_ff[bsc_pkg::DIV_STAGES-1];
   assign rsp.side  = side_ff[bsc_pkg::DIV_STAGES-1];

endmodule

### sv/bsc_mid.sv
// Stages between the two divides: B5, temperature, B3, B4 and B7.
// Depends on bsc_pkg.
module bsc_mid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  bsc_pkg::calib_type   calib,
   input  bsc_pkg::div_rsp_type div_rsp,
   output bsc_pkg::div_req_type div_req
);

   bsc_pkg::side1_type sd;
   bsc_pkg::side2_type s2;
   logic [31:0] ac1, ac2, ac3, ac4, b1, b2, qs, b5;
   logic [31:0] mul_k;

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff;

   logic [31:0] a_temp_ff, a_temp_in, a_b6_ff, a_b6_in;
   logic [23:0] a_up_ff;
   logic        a_err_ff;
   logic [31:0] b_temp_ff, b_sqp_ff, b_sqp_in, b_ac2p_ff, b_ac2p_in, b_ac3p_ff, b_ac3p_in;
   logic [23:0] b_up_ff;
   logic        b_err_ff;
   logic [31:0] c_temp_ff, c_sq_ff, c_sq_in, c_x2_ff, c_x2_in, c_x1_ff, c_x1_in;
   logic [23:0] c_up_ff;
   logic        c_err_ff;
   logic [31:0] d_temp_ff, d_x2_ff, d_x1_ff, d_b2p_ff, d_b2p_in, d_b1p_ff, d_b1p_in;
   logic [23:0] d_up_ff;
   logic        d_err_ff;
   logic [31:0] e_temp_ff, e_x3_ff, e_x3_in, e_x3b_ff, e_x3b_in;
   logic [23:0] e_up_ff;
   logic        e_err_ff;
   logic [31:0] f_temp_ff, f_b3_ff, f_b3_in, f_b4p_ff, f_b4p_in;
   logic [23:0] f_up_ff;
   logic        f_err_ff;
   logic [31:0] g_temp_ff, g_b4_ff, g_b4_in, g_b7_ff, g_b7_in;
   logic        g_err_ff;
   logic [31:0] h_temp_ff, h_num_ff, h_num_in, h_den_ff;
   logic        h_err_ff, h_err_in, h_ovf_ff;

   assign sd  = bsc_pkg::side1_type'(div_rsp.side);
   assign ac1 = bsc_pkg::half_s(calib.ac1_ac2[31:16]);
   assign ac2 = bsc_pkg::half_s(calib.ac1_ac2[15:0]);
   assign ac3 = bsc_pkg::half_s(calib.ac3_ac4[31:16]);
   assign ac4 = {16'd0, calib.ac3_ac4[15:0]};
   assign b1  = bsc_pkg::half_s(calib.b1_b2[31:16]);
   assign b2  = bsc_pkg::half_s(calib.b1_b2[15:0]);
   // 50000 >> mode
   assign mul_k = 32'd50000 >> calib.mode;

   always_comb begin
      qs        = sd.neg ? (32'd0 - div_rsp.quo) : div_rsp.quo;
      b5        = sd.x1 + qs;
      a_temp_in = bsc_pkg::sdiv_pow2(b5 + 32'd8, 5'd4);
      a_b6_in   = b5 - 32'd4000;

      b_sqp_in  = a_b6_ff * a_b6_ff;
      b_ac2p_in = ac2 * a_b6_ff;
      b_ac3p_in = ac3 * a_b6_ff;

      c_sq_in = bsc_pkg::sdiv_pow2(b_sqp_ff, 5'd12);
      c_x2_in = bsc_pkg::sdiv_pow2(b_ac2p_ff, 5'd11);
      c_x1_in = bsc_pkg::sdiv_pow2(b_ac3p_ff, 5'd13);

      d_b2p_in = b2 * c_sq_ff;
      d_b1p_in = b1 * c_sq_ff;

      e_x3_in  = bsc_pkg::sdiv_pow2(d_b2p_ff, 5'd11) + d_x2_ff;
      e_x3b_in = bsc_pkg::sdiv_pow2(d_x1_ff + bsc_pkg::sdiv_pow2(d_b1p_ff, 5'd16) + 32'd2,
                                    5'd2);

      f_b3_in  = bsc_pkg::sdiv_pow2((((ac1 << 2) + e_x3_ff) << calib.mode) + 32'd2, 5'd2);
      f_b4p_in = ac4 * (e_x3b_ff + 32'd32768);

      g_b4_in = f_b4p_ff >> 15;
      g_b7_in = ({8'd0, f_up_ff} - f_b3_ff) * mul_k;

      h_num_in = g_b7_ff[31] ? g_b7_ff : (g_b7_ff << 1);
      h_err_in = g_err_ff | (g_b4_ff == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= div_rsp.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_temp_ff <= a_temp_in;
         a_b6_ff   <= a_b6_in;
         a_up_ff   <= sd.up;
         a_err_ff  <= sd.err;

         b_temp_ff <= a_temp_ff;
         b_sqp_ff  <= b_sqp_in;
         b_ac2p_ff <= b_ac2p_in;
         b_ac3p_ff <= b_ac3p_in;
         b_up_ff   <= a_up_ff;
         b_err_ff  <= a_err_ff;

         c_temp_ff <= b_temp_ff;
         c_sq_ff   <= c_sq_in;
         c_x2_ff   <= c_x2_in;
         c_x1_ff   <= c_x1_in;
         c_up_ff   <= b_up_ff;
         c_err_ff  <= b_err_ff;

         d_temp_ff <= c_temp_ff;
         d_x2_ff   <= c_x2_ff;
         d_x1_ff   <= c_x1_ff;
         d_b2p_ff  <= d_b2p_in;
         d_b1p_ff  <= d_b1p_in;
         d_up_ff   <= c_up_ff;
         d_err_ff  <= c_err_ff;

         e_temp_ff <= d_temp_ff;
         e_x3_ff   <= e_x3_in;
         e_x3b_ff  <= e_x3b_in;
         e_up_ff   <= d_up_ff;
         e_err_ff  <= d_err_ff;

         f_temp_ff <= e_temp_ff;
         f_b3_ff   <= f_b3_in;
         f_b4p_ff  <= f_b4p_in;
         f_up_ff   <= e_up_ff;
         f_err_ff  <= e_err_ff;

         g_temp_ff <= f_temp_ff;
         g_b4_ff   <= g_b4_in;
         g_b7_ff   <= g_b7_in;
         g_err_ff  <= f_err_ff;

         h_temp_ff <= g_temp_ff;
         h_num_ff  <= h_num_in;
         h_den_ff  <= g_b4_ff;
         h_err_ff  <= h_err_in;
         h_ovf_ff  <= g_b7_ff[31];
      end
   end

   always_comb begin
      s2.ovf  = h_ovf_ff;
      s2.err  = h_err_ff;
      s2.temp = h_temp_ff;
   end

   assign div_req.valid = h_valid_ff;
   assign div_req.num   = h_num_ff;
   assign div_req.den   = h_den_ff;
   assign div_req.side  = bsc_pkg::SIDE_W'(s2);

endmodule

### sv/bsc_tail.sv
// Final pressure correction polynomial and the result register.
// Depends on bsc_pkg.
module bsc_tail (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  bsc_pkg::div_rsp_type div_rsp,
   output bsc_pkg::res_type     res
);

   bsc_pkg::side2_type sd;
   logic [31:0] pres;

   logic        p_valid_ff, q_valid_ff, r_valid_ff, o_valid_ff;
   logic [31:0] p_temp_ff, p_pres_ff, p_x1_ff, p_x1_in, p_m_ff, p_m_in;
   logic        p_err_ff;
   logic [31:0] q_temp_ff, q_pres_ff, q_sqp_ff, q_sqp_in, q_x2_ff, q_x2_in;
   logic        q_err_ff;
   logic [31:0] r_temp_ff, r_pres_ff, r_m_ff, r_m_in, r_x2_ff;
   logic        r_err_ff;
   logic [31:0] o_temp_ff, o_temp_in, o_pres_ff, o_pres_in;
   logic        o_err_ff;

   assign sd = bsc_pkg::side2_type'(div_rsp.side[bsc_pkg::SIDE2_W-1:0]);

   always_comb begin
      pres      = sd.ovf ? (div_rsp.quo << 1) : div_rsp.quo;
      p_x1_in   = bsc_pkg::sdiv_pow2(pres, 5'd8);
      p_m_in    = pres * 32'd7357;
      q_sqp_in  = p_x1_ff * p_x1_ff;
      q_x2_in   = bsc_pkg::sdiv_pow2(32'd0 - p_m_ff, 5'd16);
      r_m_in    = q_sqp_ff * 32'd3038;
      o_pres_in = r_pres_ff + bsc_pkg::sdiv_pow2(
                     bsc_pkg::sdiv_pow2(r_m_ff, 5'd16) + r_x2_ff + 32'd3791, 5'd4);
      o_temp_in = r_temp_ff;
      if (r_err_ff) begin
         o_pres_in = '0;
         o_temp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= div_rsp.valid;
         q_valid_ff <= p_valid_ff;
         r_valid_ff <= q_valid_ff;
         o_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_temp_ff <= sd.temp;
         p_pres_ff <= pres;
         p_x1_ff   <= p_x1_in;
         p_m_ff    <= p_m_in;
         p_err_ff  <= sd.err;

         q_temp_ff <= p_temp_ff;
         q_pres_ff <= p_pres_ff;
         q_sqp_ff  <= q_sqp_in;
         q_x2_ff   <= q_x2_in;
         q_err_ff  <= p_err_ff;

         r_temp_ff <= q_temp_ff;
         r_pres_ff <= q_pres_ff;
         r_m_ff    <= r_m_in;
         r_x2_ff   <= q_x2_ff;
         r_err_ff  <= q_err_ff;

         o_temp_ff <= o_temp_in;
         o_pres_ff <= o_pres_in;
         o_err_ff  <= r_err_ff;
      end
   end

   assign res.valid = o_valid_ff;
   assign res.temp  = o_temp_ff;
   assign res.pres  = o_pres_ff;
   assign res.err   = o_err_ff;

endmodule

### sv/barometric_sensor_compensation_core.sv
// Top level of the compensation core: register file, front stages, two dividers.
// Depends on bsc_pkg, bsc_div, bsc_mid, bsc_tail and the defines header.
//
// Usage
//  - req_ beats carry one raw reading: raw_temperature and raw_pressure.
//  - rsp_ beats carry one result per reading, in order: temperature in
//    tenths of a degree, pressure in pascals, and divide_error in tuser.
//  - csr_ writes the five calibration words and the oversampling mode;
//    csr_ready is always high, unknown indexes are dropped. Write only
//    while no reading is in flight.
//  - Pipeline: two front stages, a 32-stage temperature divider (one
//    quotient bit a stage), eight coefficient stages, a 32-stage
//    pressure divider and four tail stages; 78 registers, the first loaded
//    at the accepting edge itself and the last driving rsp_tvalid.
//  - Throughput: one reading every cycle unless stalled; every stage is a
//    register with a valid bit; new beats enter while older are in flight.
//  - Reset clears the valid bits and the calibration registers to zero.
//  - Stall: when rsp_tvalid is high and rsp_tready low the whole pipeline
//    freezes and req_tready drops, so nothing is lost or repeated.
//  - A zero divisor (X1+MD or B4) gives zero results with divide_error set.
`include "barometric_sensor_compensation_core_defines.svh"

module barometric_sensor_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] temperature_tenths, [63:32] pressure_pascal
   output logic [0:0]  rsp_tuser,   // [0] divide_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   bsc_pkg::calib_type   calib_ff;
   bsc_pkg::div_req_type div1_req, div2_req;
   bsc_pkg::div_rsp_type div1_rsp, div2_rsp;
   bsc_pkg::res_type     res;
   bsc_pkg::side1_type   s2_side_in;

   logic        en;
   logic [31:0] ut, mcx, x1, divt;

   // front stage 1: shifted pressure and (UT - AC6) * AC5
   logic        s1_valid_ff;
   logic [31:0] s1_prod_ff, s1_prod_in;
   logic [23:0] s1_up_ff, s1_up_in;

   // front stage 2: operands for the temperature divide
   logic        s2_valid_ff;
   logic [31:0] s2_num_ff, s2_num_in, s2_den_ff, s2_den_in;
   logic [bsc_pkg::SIDE_W-1:0] s2_side_ff;

   // whole pipeline advances unless the result register is held
   assign en         = !res.valid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bsc_pkg::CSR_AC1_AC2: calib_ff.ac1_ac2 <= csr_data;
            bsc_pkg::CSR_AC3_AC4: calib_ff.ac3_ac4 <= csr_data;
            bsc_pkg::CSR_AC5_AC6: calib_ff.ac5_ac6 <= csr_data;
            bsc_pkg::CSR_B1_B2:   calib_ff.b1_b2   <= csr_data;
            bsc_pkg::CSR_MC_MD:   calib_ff.mc_md   <= csr_data;
            bsc_pkg::CSR_MODE:    calib_ff.mode    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ut         = {16'd0, req_tdata[15:0]};
      s1_prod_in = (ut - {16'd0, calib_ff.ac5_ac6[15:0]}) * {16'd0, calib_ff.ac5_ac6[31:16]};
      s1_up_in   = req_tdata[39:16] >> (4'd8 - {2'd0, calib_ff.mode});

      // X2 = MC * 2048 / (X1 + MD), done on magnitudes with the sign on the side
      x1   = bsc_pkg::sdiv_pow2(s1_prod_ff, 5'd15);
      divt = x1 + bsc_pkg::half_s(calib_ff.mc_md[15:0]);
      mcx  = bsc_pkg::half_s(calib_ff.mc_md[31:16]) << 11;
      s2_num_in = mcx[31] ? (32'd0 - mcx) : mcx;
      s2_den_in = divt[31] ? (32'd0 - divt) : divt;
      s2_side_in.neg = mcx[31] ^ divt[31];
      s2_side_in.err = (divt == 32'd0);
      s2_side_in.up  = s1_up_ff;
      s2_side_in.x1  = x1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= s1_up_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_side_ff <= s2_side_in;
      end
   end

   assign div1_req.valid = s2_valid_ff;
   assign div1_req.num   = s2_num_ff;
   assign div1_req.den   = s2_den_ff;
   assign div1_req.side  = s2_side_ff;

   bsc_div u_div_temp (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .req   (div1_req),
      .rsp   (div1_rsp)
   );

   bsc_mid u_mid (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .calib   (calib_ff),
      .div_rsp (div1_rsp),
      .div_req (div2_req)
   );

   bsc_div u_div_pres (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .req   (div2_req),
      .rsp   (div2_rsp)
   );

   bsc_tail u_tail (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_rsp (div2_rsp),
      .res     (res)
   );

   assign rsp_tvalid   = res.valid;
   assign rsp_tdata    = {res.pres, res.temp};
   assign rsp_tuser[0] = res.err;

   `BSC_ASSERT_SAME(a_err_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == 64'd0, "error result not zero")
   `BSC_ASSERT_NEXT(a_entry, req_tvalid && req_tready, s1_valid_ff, "accepted beat not in stage one")
   `BSC_ASSERT_NEXT(a_freeze, !req_tready, s1_valid_ff == $past(s1_valid_ff), "pipeline moved in stall")

endmodule
